### hw/rtl/bos_pkg.sv
// Shared constants, codes and types of the box overlap screen.
package bos_pkg;

    localparam int MAX_BODIES = 32;
    localparam int BODY_AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    // command codes (s_axis_tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_FRACTION = 1'b0;
    localparam logic CFG_ACTIVE   = 1'b1;

    // one stored segment: frame span and box
    typedef struct packed {
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [11:0] box_w;
        logic [11:0] box_h;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

endpackage

### hw/rtl/bos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bos_ram #(
    parameter int P_W = 8,
    parameter int P_D = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((P_D > 1) ? $clog2(P_D) : 1)-1:0] i_waddr,
    input  logic [P_W-1:0]                         i_wdata,
    input  logic [((P_D > 1) ? $clog2(P_D) : 1)-1:0] i_raddr,
    output logic [P_W-1:0]                         o_rdata
);

    logic [P_W-1:0] r_mem [P_D];
    logic [P_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/box_overlap_screen_core.sv
// Top level of the box overlap screen: segment table, query walk and result port.
//
// Usage:
//   s_axis carries command words. tuser = 0 writes one segment (span and box)
//   of one body; tuser = 1 runs a query: the query box is tested against every
//   active body other than its own, using the segment that applies at the
//   query frame. m_axis returns one word per query: tuser = is_clear, tdata
//   low bits = index of the first blocking body (0 when clear).
//   Config (i_cfg_we/i_cfg_index/i_cfg_wdata) sets the overlap fraction
//   (1/256 units) and the number of active bodies; write it only when idle.
// Timing:
//   s_axis_tready stays high across segment writes.
//   A query walks the active bodies (capped at 32) over the two segment
//   RAMs at one body per cycle, ending early when a blocker is found, and
//   feeds one shared multiplier (query area, area threshold, then each
//   overlap area). s_axis_tready is low while a query is in progress and
//   rises as the result is loaded into the output register.
// Reset: all segments invalid, fraction 128, active bodies 0, output empty.
// Stall: the result sits in the output register; another command word is
//   taken meanwhile, and a following query waits at its end for the slot.
module box_overlap_screen_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cmd in: tdata = body_index[4:0], segment_slot[5], segment_valid[6],
    // span_start[22:7], span_end[38:23], box_x[50:39], box_y[62:51],
    // box_w[74:63], box_h[86:75], query_frame[102:87], zero pad[103]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tuser,  // cmd
    // result out: tdata = blocking_index[4:0], zero pad[7:5]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tuser,  // is_clear
    // config write port
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [8:0]   i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_QA   = 6'b000010,  // query area w*h
        S_QN   = 6'b000100,  // threshold area*fraction
        S_NEED = 6'b001000,  // latch threshold
        S_WALK = 6'b010000,  // scan bodies
        S_FIN  = 6'b100000   // hand result to output register
    } t_state;

    localparam int AW = bos_pkg::BODY_AW;
    localparam int CW = bos_pkg::CNT_W;

    // ---------------- input word unpack ----------------
    logic [4:0]  in_body;
    logic        in_slot;
    logic        in_valid;
    bos_pkg::t_seg in_seg;
    logic [15:0] in_frame;

    assign in_body            = s_axis_tdata[4:0];
    assign in_slot            = s_axis_tdata[5];
    assign in_valid           = s_axis_tdata[6];
    assign in_seg.span_start  = s_axis_tdata[22:7];
    assign in_seg.span_end    = s_axis_tdata[38:23];
    assign in_seg.box_x       = s_axis_tdata[50:39];
    assign in_seg.box_y       = s_axis_tdata[62:51];
    assign in_seg.box_w       = s_axis_tdata[74:63];
    assign in_seg.box_h       = s_axis_tdata[86:75];
    assign in_frame           = s_axis_tdata[102:87];

    // ---------------- registers ----------------
    t_state          r_state, n_state;
    logic [8:0]      r_frac;
    logic [5:0]      r_active;
    logic [bos_pkg::MAX_BODIES-1:0] r_val0, r_val1;  // segment valid bits

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_issue, n_issue;
    logic            r_v1, n_v1, r_v2, n_v2, r_v3, n_v3;
    logic [AW-1:0]   r_i1, r_i2, r_i3;
    logic            r_e2, r_e3;
    logic [11:0]     r_ow, r_oh;
    logic [35:0]     r_prod;
    logic [32:0]     r_need;

    logic [11:0]     r_qx, r_qy, r_qw, r_qh;
    logic [15:0]     r_qframe;
    logic [4:0]      r_qbody;

    logic            r_res_clear, n_res_clear;
    logic [4:0]      r_res_idx, n_res_idx;
    logic            r_out_valid, n_out_valid;
    logic            r_out_clear;
    logic [4:0]      r_out_idx;

    logic s_acc, wr_hit, query_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign query_acc     = s_acc && (s_axis_tuser == bos_pkg::CMD_QUERY);
    assign wr_hit        = s_acc && (s_axis_tuser == bos_pkg::CMD_WRITE)
                           && (32'(in_body) < bos_pkg::MAX_BODIES);

    // ---------------- segment RAMs, one per slot ----------------
    logic [bos_pkg::SEG_W-1:0] rd0_bits, rd1_bits;
    bos_pkg::t_seg             rd0, rd1;
    logic [AW-1:0]             waddr, raddr;

    assign waddr = AW'(in_body);
    assign raddr = r_issue[AW-1:0];

    bos_ram #(.P_W(bos_pkg::SEG_W), .P_D(bos_pkg::MAX_BODIES)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (wr_hit && !in_slot),
        .i_waddr (waddr),
        .i_wdata (in_seg),
        .i_raddr (raddr),
        .o_rdata (rd0_bits)
    );

    bos_ram #(.P_W(bos_pkg::SEG_W), .P_D(bos_pkg::MAX_BODIES)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (wr_hit && in_slot),
        .i_waddr (waddr),
        .i_wdata (in_seg),
        .i_raddr (raddr),
        .o_rdata (rd1_bits)
    );

    assign rd0 = rd0_bits;
    assign rd1 = rd1_bits;

    // ---------------- stage 1: segment choice and intersection ----------------
    logic          own, v0, v1, use0, use1, elig;
    bos_pkg::t_seg sel;
    logic [11:0]   left, top;
    logic [12:0]   right, bottom, q_r, q_b, s_r, s_b;
    logic [11:0]   ow, oh;

    always_comb begin
        own  = (32'(r_i1) == 32'(r_qbody));
        v0   = r_val0[r_i1];
        v1   = r_val1[r_i1];
        // frame inside segment 0
        use0 = !own && v0 && (r_qframe >= rd0.span_start) && (r_qframe <= rd0.span_end);
        // frame past segment 0, inside a valid segment 1
        use1 = !own && v0 && (r_qframe >= rd0.span_start) && (r_qframe > rd0.span_end)
               && v1 && (r_qframe >= rd1.span_start) && (r_qframe <= rd1.span_end);
        elig = use0 | use1;
        sel  = use0 ? rd0 : rd1;

        q_r    = {1'b0, r_qx} + {1'b0, r_qw};
        q_b    = {1'b0, r_qy} + {1'b0, r_qh};
        s_r    = {1'b0, sel.box_x} + {1'b0, sel.box_w};
        s_b    = {1'b0, sel.box_y} + {1'b0, sel.box_h};
        left   = (r_qx > sel.box_x) ? r_qx : sel.box_x;
        top    = (r_qy > sel.box_y) ? r_qy : sel.box_y;
        right  = (q_r < s_r) ? q_r : s_r;
        bottom = (q_b < s_b) ? q_b : s_b;
        // empty overlap when width or height is not positive
        ow = (right  > {1'b0, left}) ? 12'(right  - {1'b0, left}) : 12'd0;
        oh = (bottom > {1'b0, top})  ? 12'(bottom - {1'b0, top})  : 12'd0;
    end

    // ---------------- shared multiplier ----------------
    logic [23:0] mul_a;
    logic [11:0] mul_b;

    always_comb begin
        case (r_state)
            S_QA:    begin mul_a = {12'd0, r_qw};  mul_b = r_qh;          end
            S_QN:    begin mul_a = r_prod[23:0];   mul_b = {3'd0, r_frac}; end
            default: begin mul_a = {12'd0, r_ow};  mul_b = r_oh;          end
        endcase
    end

    // ---------------- stage 3: threshold compare ----------------
    logic ge, hit3, issue;
    assign ge    = {2'd0, r_prod[23:0], 8'd0} >= {1'b0, r_need};
    assign hit3  = r_v3 && r_e3 && ge;
    assign issue = (r_issue < r_count);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_v1        = 1'b0;
        n_v2        = 1'b0;
        n_v3        = 1'b0;
        n_res_clear = r_res_clear;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (query_acc) begin
                    n_state = S_QA;
                    n_issue = '0;
                end
            end
            S_QA:   n_state = S_QN;
            S_QN:   n_state = S_NEED;
            S_NEED: n_state = S_WALK;
            S_WALK: begin
                if (hit3) begin
                    // first blocker wins; younger entries in flight are dropped
                    n_state     = S_FIN;
                    n_res_clear = 1'b0;
                    n_res_idx   = 5'(r_i3);
                end else if (!issue && !r_v1 && !r_v2 && !r_v3) begin
                    n_state     = S_FIN;
                    n_res_clear = 1'b1;
                    n_res_idx   = 5'd0;
                end else begin
                    n_v1 = issue;
                    n_v2 = r_v1;
                    n_v3 = r_v2;
                    if (issue) begin
                        n_issue = r_issue + CW'(1);
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frac      <= 9'd128;
            r_active    <= 6'd0;
            r_val0      <= '0;
            r_val1      <= '0;
            r_count     <= '0;
            r_issue     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_v3        <= n_v3;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bos_pkg::CFG_FRACTION: r_frac   <= i_cfg_wdata;
                    bos_pkg::CFG_ACTIVE:   r_active <= i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (wr_hit) begin
                if (in_slot) begin
                    r_val1[waddr] <= in_valid;
                end else begin
                    r_val0[waddr] <= in_valid;
                end
            end
            if (query_acc) begin
                r_count <= (32'(r_active) > bos_pkg::MAX_BODIES)
                           ? CW'(bos_pkg::MAX_BODIES) : CW'(r_active);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prod      <= 36'(mul_a) * 36'(mul_b);
        r_i1        <= r_issue[AW-1:0];
        r_i2        <= r_i1;
        r_i3        <= r_i2;
        r_e2        <= elig;
        r_e3        <= r_e2;
        r_ow        <= ow;
        r_oh        <= oh;
        r_res_clear <= n_res_clear;
        r_res_idx   <= n_res_idx;
        if (r_state == S_NEED) begin
            r_need <= r_prod[32:0];
        end
        if (query_acc) begin
            r_qx     <= in_seg.box_x;
            r_qy     <= in_seg.box_y;
            r_qw     <= in_seg.box_w;
            r_qh     <= in_seg.box_h;
            r_qframe <= in_frame;
            r_qbody  <= in_body;
        end
        if (r_state == S_FIN && (!r_out_valid || m_axis_tready)) begin
            r_out_clear <= r_res_clear;
            r_out_idx   <= r_res_idx;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_clear;
    assign m_axis_tdata  = {3'd0, r_out_idx};

    // ---------------- assertions ----------------
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |=> (r_state == S_QA))
        else $error("query accepted but sequencer did not start");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_issue <= r_count))
        else $error("walk issued past the active body count");

    a_no_self_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && hit3) |-> (32'(r_i3) != 32'(r_qbody)))
        else $error("query blocked by its own body");

    a_clear_zero_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clear) |-> (r_out_idx == 5'd0))
        else $error("clear result carries nonzero index");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_idx)
                                             && $stable(r_out_clear)))
        else $error("pending result lost or changed under stall");

endmodule

### tb/sv/box_overlap_screen_core_tb.sv
// Self-checking testbench of box_overlap_screen_core: directed and random command words.
module box_overlap_screen_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles allowed after the last result before a config write or the verdict:
    // one full query walk plus margin, so a late stray word still gets caught.
    localparam int DRAIN_CYCLES  = bos_pkg::MAX_BODIES + 32;
    localparam int ROUNDS        = 27;
    localparam int WORDS_PER_RND = 48;
    localparam int FRAME_WINDOW  = 200;   // busy frame range of the random table
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off

    // One command word as it travels on s_axis.
    typedef struct packed {
        logic        cmd;
        logic [4:0]  body;
        logic        slot;
        logic        seg_valid;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [15:0] frame;
    } t_screen_word;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } t_box;

    typedef struct packed {
        logic       is_clear;
        logic [4:0] blocker;
    } t_verdict;

    logic         i_clk          = 1'b0;
    logic         i_rst_n        = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata   = '0;
    logic         s_axis_tuser   = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we       = 1'b0;
    logic         i_cfg_index    = 1'b0;
    logic [8:0]   i_cfg_wdata    = '0;

    box_overlap_screen_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block: segment table and config, updated as words are
    // accepted. Boxes are only read through a valid segment, and a segment
    // only turns valid by a write, so the zero start values are never used.
    // ------------------------------------------------------------------
    logic        seg_live  [2*bos_pkg::MAX_BODIES] = '{default: 1'b0};
    logic [15:0] seg_first [2*bos_pkg::MAX_BODIES] = '{default: '0};
    logic [15:0] seg_last  [2*bos_pkg::MAX_BODIES] = '{default: '0};
    t_box        seg_box   [2*bos_pkg::MAX_BODIES] = '{default: '0};
    logic [8:0]  fraction_reg = 9'd128;
    logic [5:0]  active_reg   = 6'd0;

    t_screen_word pending_words[$];      // filled by the stimulus, drained by the driver
    t_verdict     expected_verdicts[$];  // one per accepted query, oldest first
    t_box         recent_boxes[$];       // boxes lately written, reused by queries
    t_screen_word word_on_bus;
    int           pushed_words    = 0;
    int           accepted_words  = 0;
    int           mismatch_count  = 0;
    int           send_idle_pct   = 0;
    int           recv_idle_pct   = 0;
    int           hold_cycles_left = 0;
    int           hold_requests   = 0;   // bumped by the stimulus to start a hold-off
    int           hold_served     = 0;

    // Apply one accepted word: a write loads the shadow table, a query walks
    // the active bodies and queues the verdict the block must return.
    function automatic void screen_apply(t_screen_word wd);
        int unsigned scan, k, left, top, right, bottom, ra, rb;
        longint unsigned need, area;
        int pick;
        t_verdict v;
        if (wd.cmd == bos_pkg::CMD_WRITE) begin
            k = 2 * 32'(wd.body) + 32'(wd.slot);
            seg_live[k]  = wd.seg_valid;
            seg_first[k] = wd.span_start;
            seg_last[k]  = wd.span_end;
            seg_box[k]   = '{x: wd.x, y: wd.y, w: wd.w, h: wd.h};
            return;
        end
        // active count above the table size saturates
        scan = (32'(active_reg) > bos_pkg::MAX_BODIES) ? bos_pkg::MAX_BODIES
                                                       : 32'(active_reg);
        need = 64'(wd.w) * 64'(wd.h) * 64'(fraction_reg);
        v.is_clear = 1'b1;
        v.blocker  = '0;
        for (int i = 0; i < scan; i++) begin
            if (i == wd.body || !seg_live[2*i] || wd.frame < seg_first[2*i])
                continue;
            pick = -1;
            if (wd.frame <= seg_last[2*i]) begin
                pick = 2 * i;
            end else if (seg_live[2*i+1] && wd.frame >= seg_first[2*i+1]
                         && wd.frame <= seg_last[2*i+1]) begin
                pick = 2 * i + 1;
            end
            if (pick < 0)
                continue;
            left   = (wd.x > seg_box[pick].x) ? 32'(wd.x) : 32'(seg_box[pick].x);
            top    = (wd.y > seg_box[pick].y) ? 32'(wd.y) : 32'(seg_box[pick].y);
            ra     = 32'(wd.x) + 32'(wd.w);
            rb     = 32'(seg_box[pick].x) + 32'(seg_box[pick].w);
            right  = (ra < rb) ? ra : rb;
            ra     = 32'(wd.y) + 32'(wd.h);
            rb     = 32'(seg_box[pick].y) + 32'(seg_box[pick].h);
            bottom = (ra < rb) ? ra : rb;
            area = (right > left && bottom > top) ?
                   64'(right - left) * 64'(bottom - top) : 64'd0;
            if (area * 256 >= need) begin
                v.is_clear = 1'b0;
                v.blocker  = 5'(i);
                break;
            end
        end
        expected_verdicts = {expected_verdicts, v};
    endfunction

    // ------------------------------------------------------------------
    // Driver: holds a word until it is taken, then may idle at random before the next.
    // The word is applied to the shadow at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                screen_apply(word_on_bus);
                accepted_words++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_on_bus = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= word_on_bus.cmd;
                    s_axis_tdata  <= {1'b0, word_on_bus.frame, word_on_bus.h,
                                      word_on_bus.w, word_on_bus.y, word_on_bus.x,
                                      word_on_bus.span_end, word_on_bus.span_start,
                                      word_on_bus.seg_valid, word_on_bus.slot,
                                      word_on_bus.body};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request and counted down here.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served      <= hold_requests;
            hold_cycles_left <= HOLD_CYCLES;
        end else if (hold_cycles_left > 0) begin
            hold_cycles_left <= hold_cycles_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result word with the oldest verdict.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result word with no query pending: is_clear=%0b blocking_index=%0d",
                           m_axis_tuser, m_axis_tdata[4:0]);
                    mismatch_count++;
                end else begin
                    exp_v = expected_verdicts.pop_front();
                    if (m_axis_tuser !== exp_v.is_clear) begin
                        $error("is_clear: expected %0b, got %0b", exp_v.is_clear, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[4:0] !== exp_v.blocker) begin
                        $error("blocking_index: expected %0d, got %0d",
                               exp_v.blocker, m_axis_tdata[4:0]);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= (hold_cycles_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(t_screen_word wd);
        pending_words = {pending_words, wd};
        pushed_words++;
    endtask

    task automatic put_segment(input logic [4:0] body, input logic slot, input logic live,
                               input logic [15:0] first, input logic [15:0] last,
                               input logic [11:0] x, input logic [11:0] y,
                               input logic [11:0] w, input logic [11:0] h);
        push_word('{cmd: bos_pkg::CMD_WRITE, body: body, slot: slot, seg_valid: live,
                    span_start: first, span_end: last, x: x, y: y, w: w, h: h, frame: '0});
    endtask

    task automatic put_query(input logic [4:0] body, input logic [15:0] frame,
                             input logic [11:0] x, input logic [11:0] y,
                             input logic [11:0] w, input logic [11:0] h);
        push_word('{cmd: bos_pkg::CMD_QUERY, body: body, slot: 1'b0, seg_valid: 1'b0,
                    span_start: '0, span_end: '0, x: x, y: y, w: w, h: h, frame: frame});
    endtask

    // Wait until every word is taken and every verdict returned, then let
    // a full walk's worth of cycles pass so the block is surely idle.
    task automatic settle();
        while (accepted_words != pushed_words) @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write; the shadow copy follows right away (block is idle).
    task automatic cfg_write(input logic idx, input logic [8:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        if (idx == bos_pkg::CFG_FRACTION)
            fraction_reg = value;
        else
            active_reg = value[5:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly small boxes near the origin so overlaps are common; some full range.
    function automatic t_box random_box();
        t_box b;
        if ($urandom_range(9) < 7) begin
            b.x = 12'($urandom_range(255));
            b.y = 12'($urandom_range(255));
            b.w = 12'($urandom_range(127));
            b.h = 12'($urandom_range(127));
        end else begin
            b.x = 12'($urandom_range(4095));
            b.y = 12'($urandom_range(4095));
            b.w = 12'($urandom_range(4095));
            b.h = 12'($urandom_range(4095));
        end
        return b;
    endfunction

    // Random word: fields a command ignores still get random bits.
    task automatic add_random_word();
        t_screen_word wd;
        t_box b;
        wd.body       = 5'($urandom_range(31));
        wd.slot       = 1'($urandom_range(1));
        wd.seg_valid  = 1'($urandom_range(1));
        wd.span_start = 16'($urandom);
        wd.span_end   = 16'($urandom);
        wd.frame      = 16'($urandom);
        b = random_box();
        if ($urandom_range(99) < 40) begin
            wd.cmd = bos_pkg::CMD_WRITE;
            wd.seg_valid = ($urandom_range(9) != 0);
            // ordered span starting inside the busy window, now and then a wild one
            if ($urandom_range(9) != 0) begin
                wd.span_start = 16'($urandom_range(FRAME_WINDOW - 1));
                wd.span_end   = 16'(wd.span_start + $urandom_range(60));
            end
            recent_boxes = {recent_boxes, b};
            if (recent_boxes.size() > 8)
                void'(recent_boxes.pop_front());
        end else begin
            wd.cmd = bos_pkg::CMD_QUERY;
            if ($urandom_range(9) != 0)
                wd.frame = 16'($urandom_range(FRAME_WINDOW + 40));
            // near copy of a stored box: hits the threshold region often
            if (recent_boxes.size() > 0 && $urandom_range(3) == 0) begin
                b = recent_boxes[$urandom_range(recent_boxes.size() - 1)];
                b.x = 12'(b.x + $urandom_range(16) - 8);
                b.y = 12'(b.y + $urandom_range(16) - 8);
                b.w = 12'(b.w + $urandom_range(8) - 4);
            end
        end
        wd.x = b.x;
        wd.y = b.y;
        wd.w = b.w;
        wd.h = b.h;
        push_word(wd);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned frac_pick, act_pick;
        logic [8:0] frac_edges [8] = '{9'd0, 9'd1, 9'd64, 9'd128,
                                       9'd255, 9'd256, 9'd257, 9'd511};
        logic [5:0] act_edges  [8] = '{6'd32, 6'd0, 6'd1, 6'd31,
                                       6'd32, 6'd33, 6'd63, 6'd32};

        send_idle_pct = 36;
        recv_idle_pct = 68;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: fraction 128, no active bodies.
        // body 0: two segments with a frame gap; body 1: only segment 1 valid
        // (must be skipped); body 31: extreme box at the last frame.
        put_segment(5'd0,  1'b0, 1'b1, 16'd100,   16'd200,   12'd100,  12'd100,  12'd50,   12'd50);
        put_segment(5'd0,  1'b1, 1'b1, 16'd300,   16'd400,   12'd1000, 12'd1000, 12'd40,   12'd40);
        put_segment(5'd1,  1'b0, 1'b0, 16'd0,     16'd65535, 12'd0,    12'd0,    12'd4095, 12'd4095);
        put_segment(5'd1,  1'b1, 1'b1, 16'd0,     16'd65535, 12'd0,    12'd0,    12'd4095, 12'd4095);
        put_segment(5'd31, 1'b0, 1'b1, 16'd65535, 16'd65535, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        put_query(5'd5, 16'd150, 12'd100, 12'd100, 12'd50, 12'd50);   // nothing scanned
        settle();

        // Scan the whole table; fraction still at its reset value.
        cfg_write(bos_pkg::CFG_ACTIVE, 9'd32);
        @(negedge i_clk);
        put_query(5'd5,  16'd150,   12'd100,  12'd100,  12'd50, 12'd50);   // full overlap
        put_query(5'd0,  16'd150,   12'd100,  12'd100,  12'd50, 12'd50);   // own body skipped
        put_query(5'd5,  16'd99,    12'd100,  12'd100,  12'd50, 12'd50);   // before span
        put_query(5'd5,  16'd200,   12'd100,  12'd100,  12'd50, 12'd50);   // span end inclusive
        put_query(5'd5,  16'd250,   12'd100,  12'd100,  12'd50, 12'd50);   // between segments
        put_query(5'd5,  16'd300,   12'd1000, 12'd1000, 12'd40, 12'd40);   // second segment
        put_query(5'd5,  16'd401,   12'd1000, 12'd1000, 12'd40, 12'd40);   // past both
        put_query(5'd5,  16'd150,   12'd125,  12'd100,  12'd50, 12'd50);   // exactly half
        put_query(5'd5,  16'd150,   12'd126,  12'd100,  12'd50, 12'd50);   // just under half
        put_query(5'd5,  16'd150,   12'd150,  12'd100,  12'd50, 12'd50);   // edges touch
        put_query(5'd5,  16'd150,   12'd4000, 12'd4000, 12'd0,  12'd0);    // empty query box
        put_query(5'd0,  16'd65535, 12'd4095, 12'd4095, 12'd4095, 12'd4095); // blocked by 31
        put_query(5'd31, 16'd65535, 12'd4095, 12'd4095, 12'd4095, 12'd4095); // 31 is itself
        put_segment(5'd0, 1'b1, 1'b0, 16'd300, 16'd400, 12'd1000, 12'd1000, 12'd40, 12'd40);
        put_query(5'd5,  16'd350,   12'd1000, 12'd1000, 12'd40, 12'd40);   // segment dropped
        settle();

        // Zero fraction: touching boxes block; active above table size saturates.
        cfg_write(bos_pkg::CFG_FRACTION, 9'd0);
        cfg_write(bos_pkg::CFG_ACTIVE, 9'd40);
        @(negedge i_clk);
        put_query(5'd5, 16'd150, 12'd150, 12'd100, 12'd50, 12'd50);
        settle();

        // Full fraction: only complete cover blocks.
        cfg_write(bos_pkg::CFG_FRACTION, 9'd256);
        @(negedge i_clk);
        put_query(5'd5, 16'd150, 12'd100, 12'd100, 12'd50, 12'd50);
        put_query(5'd5, 16'd150, 12'd100, 12'd100, 12'd50, 12'd51);
        settle();

        // Fraction above 256: only an empty box blocks. One active body.
        cfg_write(bos_pkg::CFG_FRACTION, 9'd511);
        cfg_write(bos_pkg::CFG_ACTIVE, 9'd1);
        @(negedge i_clk);
        put_query(5'd5, 16'd150,   12'd100,  12'd100,  12'd50,   12'd50);
        put_query(5'd5, 16'd150,   12'd0,    12'd0,    12'd0,    12'd0);
        put_query(5'd0, 16'd65535, 12'd4095, 12'd4095, 12'd4095, 12'd4095); // 31 not scanned
        settle();

        // Random rounds, new settings each round, three idling phases.
        for (int r = 0; r < ROUNDS; r++) begin
            if (r < 8) begin
                frac_pick = frac_edges[r];
                act_pick  = act_edges[r];
            end else begin
                frac_pick = ($urandom_range(9) < 7) ? $urandom_range(256) : $urandom_range(511);
                act_pick  = ($urandom_range(9) < 6) ? 32 : $urandom_range(63);
            end
            cfg_write(bos_pkg::CFG_FRACTION, 9'(frac_pick));
            cfg_write(bos_pkg::CFG_ACTIVE, 9'(act_pick));
            @(negedge i_clk);
            case (r / (ROUNDS / 3))
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < WORDS_PER_RND; n++)
                add_random_word();
            // first no-idle round: stop the receiver for a while so the
            // output slot fills and the input side backs up
            if (r == 2 * (ROUNDS / 3)) begin
                @(posedge i_clk);
                hold_requests++;
            end
            settle();
        end

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
